// File: rtl/ssis_pkg.sv
// shared types and constants for the sorted store with insert and search
`timescale 1ns / 1ps
`default_nettype none

package ssis_pkg;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 7;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_CLEAR  = 2'd0;
    localparam opcode_t OP_INSERT = 2'd1;
    localparam opcode_t OP_SEARCH = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    // outcome of one signed compare of a stored entry against the operand
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/ssis_if.sv
// command and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface ssis_cmd_if
    import ssis_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    value_t  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface ssis_rsp_if
    import ssis_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic              status;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, output found, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input found, input status, input fill_count,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/ssis_ram.sv
// generic simple dual port ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ssis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/ssis_cmp.sv
// shared signed comparator used by both insert shifting and search
`timescale 1ns / 1ps
`default_nettype none

module ssis_cmp
    import ssis_pkg::*;
(
    input  wire value_t   entry,
    input  wire value_t   operand,
    output cmp_res_t      res
);

    always_comb
    begin
        res.eq = (entry == operand);
        res.gt = (entry > operand);
    end

endmodule

`default_nettype wire

// File: rtl/sorted_store_insert_and_search.sv
// top level: sorted store with insert, binary search and clear
//
// usage
//   cmd channel carries opcode and value; rsp channel returns found, status and
//   fill_count, exactly one rsp transaction per cmd transaction, in order
//   clear empties the store, insert places value at its sorted position
//   (equal values land after those held), search reports whether value is held;
//   an insert into a full store returns status 1, an unused opcode changes nothing
// sequence, from cmd acceptance to the load of the response register
//   clear, unused opcode, insert into a full store: straight to the load
//   insert: reads the entry below the hole, then compares (on an empty store it
//   writes the value at once); larger entries move up one place per cycle
//   search: each probe is a ram read at the midpoint followed by its compare,
//   as the registered ram read comes ahead of each compare
//   cmd.ready returns the cycle after the load
// reset and stall
//   rst_n clears the entry count and the sequencer; ram contents are not cleared
//   a response waits in the output register while rsp.ready is low; the next
//   command is accepted meanwhile and its result is held back until it frees
`timescale 1ns / 1ps
`default_nettype none

module sorted_store_insert_and_search
    import ssis_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssis_cmd_if.sink    cmd,
    ssis_rsp_if.source  rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     j_reg, j_next;          // insert hole position
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;        // search window [lo, hi1)
    logic [CW-1:0]     hi1_reg, hi1_next;
    value_t            x_reg, x_next;
    logic              found_reg, found_next;
    logic              status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic              out_status_reg, out_status_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;

    // ram port signals
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    value_t            mem_wdata;
    value_t            mem_rdata;

    cmp_res_t          cmp;

    // midpoint of the search window, floor((lo + hi) / 2) with hi = hi1 - 1
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid_cnt;
    logic [AW-1:0]     mid;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CW + 1)'(1);
    assign mid_cnt = mid_sum[CW:1];
    assign mid     = mid_cnt[AW-1:0];

    ssis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // one comparator serves every step of insert and search
    ssis_cmp u_cmp (
        .entry   (mem_rdata),
        .operand (x_reg),
        .res     (cmp)
    );

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fill_count = out_fill_reg;

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi1_next        = hi1_reg;
        x_next          = x_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;

        mem_we    = 1'b0;
        mem_waddr = j_reg;
        mem_wdata = x_reg;
        mem_raddr = mid;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    x_next      = cmd.value;
                    found_next  = 1'b0;
                    status_next = STATUS_OK;
                    case (cmd.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                j_next     = count_reg[AW-1:0];
                                state_next = (count_reg == '0) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            lo_next    = '0;
                            hi1_next   = count_reg;
                            state_next = S_SRCH_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // fetch the entry just below the hole
            S_INS_RD:
            begin
                mem_raddr  = j_reg - AW'(1);
                state_next = S_INS_CMP;
            end

            // larger entry moves up into the hole while the next one is read; else the value fills the hole
            S_INS_CMP:
            begin
                mem_raddr = j_reg - AW'(2);
                mem_we    = 1'b1;
                if (cmp.gt)
                begin
                    mem_wdata = mem_rdata;
                    j_next    = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
            end

            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end

            // probe read at the midpoint, or stop on an empty window
            S_SRCH_RD:
            begin
                state_next = (lo_reg < hi1_reg) ? S_SRCH_CMP : S_FIN;
            end

            S_SRCH_CMP:
            begin
                if (cmp.eq)
                begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    if (cmp.gt)
                    begin
                        hi1_next = mid_cnt;
                    end
                    else
                    begin
                        lo_next = mid_cnt + CW'(1);
                    end
                    state_next = S_SRCH_RD;
                end
            end

            // hand the result to the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_fill_next   = FILL_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            j_reg          <= '0;
            lo_reg         <= '0;
            hi1_reg        <= '0;
            x_reg          <= '0;
            found_reg      <= 1'b0;
            status_reg     <= STATUS_OK;
            out_found_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            j_reg          <= j_next;
            lo_reg         <= lo_next;
            hi1_reg        <= hi1_next;
            x_reg          <= x_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
            out_found_reg  <= out_found_next;
            out_status_reg <= out_status_next;
            out_fill_reg   <= out_fill_next;
        end
    end

endmodule

`default_nettype wire
